// ----- hw/rtl/fta_pkg.sv -----
// Package: shared constants and types for the truncating float adder.
`timescale 1ns / 1ps
`default_nettype none
package fta_pkg;
  localparam logic [31:0] EXP_MASK  = 32'h7f80_0000;
  localparam int unsigned MANT_W = 24;
  localparam int unsigned SUM_W  = 25;
  localparam int unsigned LEAD_W = 5;

  typedef struct packed {
    logic                bypass;
    logic [31:0]         bypass_val;
    logic                sign;
    logic [7:0]          big_exp;
    logic [SUM_W-1:0]    sum;
  } fta_mid_t;
endpackage
`default_nettype wire

// ----- hw/rtl/fta_align.sv -----
// Operand unpack, alignment and significand add/subtract.
`timescale 1ns / 1ps
`default_nettype none
module fta_align
  import fta_pkg::*;
(
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output fta_mid_t         mid
);
  logic [7:0] ea, eb, shift_dist;
  logic [MANT_W-1:0] ma, mb, sa, sb;
  logic a_lt_b;
  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    ma = {1'b1, a[22:0]};
    mb = {1'b1, b[22:0]};
    a_lt_b = ea < eb;
    shift_dist = a_lt_b ? (eb - ea) : (ea - eb);
    sa = ma;
    sb = mb;
    if (a_lt_b) sa = (shift_dist < 8'd24) ? (ma >> shift_dist) : '0;
    else        sb = (shift_dist < 8'd24) ? (mb >> shift_dist) : '0;
    mid.bypass     = (ea == 8'd0) || (eb == 8'd0);
    mid.bypass_val = (ea == 8'd0) ? b : a;
    mid.sign       = (a[30:0] >= b[30:0]) ? a[31] : b[31];
    mid.big_exp    = a_lt_b ? eb : ea;
    if (a[31] == b[31])  mid.sum = {1'b0, sa} + {1'b0, sb};
    else if (sa > sb)    mid.sum = {1'b0, sa - sb};
    else                 mid.sum = {1'b0, sb - sa};
  end
endmodule
`default_nettype wire

// ----- hw/rtl/float32_truncating_adder.sv -----
// Top level: truncating float32 adder with registered in/out.
// Usage:
//   Input channel: in_valid/in_stall with operand_a, operand_b.
//   Output channel: out_valid/out_stall with sum_bits.
//   A request is taken when valid is high and stall is low.
//   The result passes through the input register, then the result register.
//   Throughput: one request per cycle while the output is not stalled.
//   The datapath is align/add in fta_align and normalize here, all between
//   the input register and the result register.
//   Reset clears both valid flags; payload registers are not reset.
//   When the receiver stalls, the result register holds and the input stage
//   holds once full; in_stall rises only when both stages are occupied.
`timescale 1ns / 1ps
`default_nettype none
module float32_truncating_adder
  import fta_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      sum_bits
);
  logic        s1_valid;
  logic [31:0] s1_a, s1_b;
  logic        s1_move;
  fta_mid_t    mid;
  logic [LEAD_W-1:0] lead;
  logic signed [9:0] exp_n;
  logic [SUM_W-1:0]  norm;
  logic [31:0]       result_next;

  assign s1_move  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_a <= operand_a;
      s1_b <= operand_b;
    end
  end

  fta_align u_align (.a(s1_a), .b(s1_b), .mid(mid));

  always_comb begin
    lead = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (mid.sum[i]) lead = LEAD_W'(i);
    end
    exp_n = $signed({2'b00, mid.big_exp}) + $signed({5'b0, lead}) - 10'sd23;
    if (lead == LEAD_W'(24)) norm = mid.sum >> 1;
    else                     norm = mid.sum << (LEAD_W'(23) - lead);
    if (mid.bypass)            result_next = mid.bypass_val;
    else if (mid.sum == '0)    result_next = '0;
    else if (exp_n <= 10'sd0)  result_next = '0;
    else if (exp_n > 10'sd255) result_next = {mid.sign, 31'b0} | EXP_MASK;
    else result_next = {mid.sign, exp_n[7:0], norm[22:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!(out_valid && out_stall)) begin
      out_valid <= s1_move;
    end
    if (s1_move) sum_bits <= result_next;
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stall without full pipeline");
  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result without input request");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sum_bits))
    else $error("stalled result changed");
endmodule
`default_nettype wire

// ----- tb/tb_float32_truncating_adder.sv -----
// Testbench for the truncating float32 adder: directed table plus random sums.
`timescale 1ns / 1ps
module tb_float32_truncating_adder;
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [31:0] EXP_FIELD = 32'h7f80_0000;
  localparam logic [31:0] NO_CHECK = 32'hdead_beef;
  localparam int N_DIRECTED = 20;
  localparam int N_RANDOM = 1400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] sum_bits;

  logic [31:0] sum_queue[$];
  int errors = 0;

  float32_truncating_adder i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall), .sum_bits(sum_bits)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] truncated_sum(input logic [31:0] a, input logic [31:0] b);
    logic [7:0] ea, eb, big_exp, shift_dist;
    logic [24:0] ma, mb, total;
    logic sign;
    int lead, exp_n;
    ea = a[30:23];
    eb = b[30:23];
    if (ea == 0) return b;
    if (eb == 0) return a;
    ma = {2'b01, a[22:0]};
    mb = {2'b01, b[22:0]};
    sign = (a[30:0] >= b[30:0]) ? a[31] : b[31];
    if (ea < eb) begin
      big_exp = eb;
      shift_dist = eb - ea;
      ma = (shift_dist < 24) ? (ma >> shift_dist) : '0;
    end else begin
      big_exp = ea;
      shift_dist = ea - eb;
      mb = (shift_dist < 24) ? (mb >> shift_dist) : '0;
    end
    if (a[31] == b[31]) total = ma + mb;
    else if (ma > mb) total = ma - mb;
    else total = mb - ma;
    if (total == 0) return '0;
    lead = 24;
    while (lead > 0 && !total[lead]) lead--;
    exp_n = int'(big_exp) + lead - 23;
    if (lead == 24) total = total >> 1;
    else total = total << (23 - lead);
    if (exp_n <= 0) return '0;
    if (exp_n > 255) return {sign, 31'b0} | EXP_FIELD;
    return {sign, exp_n[7:0], total[22:0]};
  endfunction

  // directed rows: a, b, expected (NO_CHECK means use the predictor)
  logic [31:0] dir_a[N_DIRECTED] = '{
    32'h0000_0000, 32'h0000_1234, 32'h3f80_0000, 32'hffff_ffff, 32'h3f80_0000,
    32'h3f80_0000, 32'h3f80_0000, 32'h4b80_0000, 32'h3fff_ffff, 32'h0080_0000,
    32'h7f7f_ffff, 32'h7fff_ffff, 32'hbf80_0000, 32'h3f80_0000, 32'h0080_0001,
    32'h4000_0000, 32'hc000_0000, 32'h3f80_0000, 32'h7f80_0000, 32'h8080_0000};
  logic [31:0] dir_b[N_DIRECTED] = '{
    32'h0000_0000, 32'h8000_5678, 32'h0000_0000, 32'h007f_ffff, 32'hbf80_0000,
    32'h3f80_0000, 32'h3380_0000, 32'h3f80_0000, 32'h3fff_ffff, 32'h8080_0001,
    32'h7f7f_ffff, 32'h7fff_ffff, 32'h3f80_0000, 32'hbf7f_ffff, 32'h8080_0000,
    32'hbf80_0000, 32'h3f80_0000, 32'h4b00_0000, 32'hff80_0000, 32'h0000_0001};
  logic [31:0] dir_sum[N_DIRECTED] = '{
    32'h0000_0000, 32'h8000_5678, 32'h3f80_0000, 32'hffff_ffff, 32'h0000_0000,
    32'h4000_0000, NO_CHECK, NO_CHECK, NO_CHECK, 32'h0000_0000,
    NO_CHECK, 32'h7f80_0000, 32'h0000_0000, NO_CHECK, 32'h0000_0000,
    NO_CHECK, NO_CHECK, NO_CHECK, 32'h0000_0000, 32'h8080_0000};

  task automatic send_request(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] want);
    in_valid <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    sum_queue.push_back(want == NO_CHECK ? truncated_sum(a, b) : want);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hff;
      2: v[30:23] = 8'($urandom_range(0, 3));
      3: v[30:23] = 8'(32'h7f + $urandom_range(0, 4) - 32'd2);
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] a, b;
    int gap;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) send_request(dir_a[i], dir_b[i], dir_sum[i]);
    in_valid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sum_queue.size() != 0) @(posedge clk);
      end
      a = rand_operand();
      b = rand_operand();
      // often pair close exponents so cancellation paths get exercised
      if ($urandom_range(0, 3) == 0) b[30:23] = 8'(a[30:23] + $urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) b = a ^ SIGN_BIT ^ $urandom_range(0, 3);
      send_request(a, b, NO_CHECK);
      if ($urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 600 < 150) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sum_queue.size() == 0) begin
        $display("%0t: unexpected result sum_bits=%h", $time, sum_bits);
        errors++;
      end else begin
        if (sum_bits !== sum_queue[0]) begin
          $display("%0t: sum_bits expected %h actual %h", $time, sum_queue[0], sum_bits);
          errors++;
        end
        void'(sum_queue.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule
